[hw/rtl/smc_pkg.sv]
// Shared types and codes for the stack machine core.
// No dependencies; every other file of the block but smc_if and smc_ram imports this package.
`default_nettype none
package smc_pkg;

  // Instruction opcodes as stored in program words.
  typedef enum logic [5:0] {
    OP_EXIT = 6'd0, OP_PUSH = 6'd1, OP_POP = 6'd2, OP_COPY = 6'd4,
    OP_ADD = 6'd5, OP_SUB = 6'd6, OP_MUL = 6'd7, OP_DIV = 6'd8, OP_MOD = 6'd9,
    OP_EQ = 6'd10, OP_NE = 6'd11, OP_GT = 6'd12, OP_LT = 6'd13, OP_GE = 6'd14,
    OP_LE = 6'd15, OP_SHL = 6'd16, OP_SHR = 6'd17, OP_LAND = 6'd18,
    OP_LOR = 6'd19, OP_BAND = 6'd20, OP_BOR = 6'd21, OP_BXOR = 6'd22,
    OP_POS = 6'd23, OP_NEG = 6'd24, OP_NOT = 6'd25, OP_INV = 6'd26,
    OP_LABEL = 6'd27, OP_JMP = 6'd28, OP_JZ = 6'd29, OP_JNZ = 6'd30,
    OP_CALL = 6'd31, OP_RET = 6'd32, OP_WI = 6'd33, OP_WC = 6'd34,
    OP_RI = 6'd36, OP_RC = 6'd37, OP_DEFINE = 6'd40, OP_DELETE = 6'd41,
    OP_ASSIGN = 6'd42, OP_LOAD = 6'd43
  } op_t;

  // Machine status codes.
  typedef enum logic [1:0] {
    HALT_RUN  = 2'd0,
    HALT_EXIT = 2'd1,
    HALT_ERR  = 2'd2
  } halt_t;

  // Kinds of printed output.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_INT  = 2'd1,
    KIND_CHAR = 2'd2
  } kind_t;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [4:0] {
    U_NOP, U_MEMWR, U_FETCH, U_DECODE, U_EXIT, U_ERR, U_RDARG, U_LDB, U_LDA,
    U_POP, U_POPB, U_PEEK, U_PUSH_B, U_PUSH_RES, U_PUSH_RV, U_DROP, U_IP1,
    U_IP2, U_ALU, U_MD_START, U_MD_STEP, U_MD_FIN, U_WOUT, U_DEF, U_DEL,
    U_ASSIGN, U_LOADRD, U_CALLPUSH, U_RET, U_RETLD, U_SRCH_INIT, U_SRCH_B
  } uop_t;

  // U_SRCH_C shares no code point: the search compare has its own command bit.
  typedef struct packed {
    uop_t uop;
    logic srch_c;
    logic take;
  } smc_cmd_t;

  typedef struct packed {
    logic [5:0] op;
    logic       op_big;
    logic       in_write;
    logic       halted;
    logic       lab_hit;
    logic       lbl_hit;
    logic       p_last;
    logic       a_zero;
    logic       md_done;
  } smc_stat_t;

  typedef enum logic [5:0] {
    S_IDLE, S_START, S_WRITE, S_FETCH, S_DECODE, S_DISPATCH, S_EXIT, S_ERR,
    S_RDARG, S_LDB, S_LDB2, S_LDA, S_POP, S_POPB, S_PEEK, S_PUSHB, S_PUSHRES,
    S_PUSHRV, S_DROP, S_IP1, S_IP2, S_ALU, S_MDSTART, S_MDSTEP, S_MDFIN,
    S_WOUT, S_DEF, S_DEL, S_ASSIGN, S_LOADRD, S_CALLPUSH, S_RET, S_RETLD,
    S_JDEC, S_SRCHINIT, S_SRCHB, S_SRCHC, S_DONE
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/smc_if.sv]
// Valid/ready channel interfaces for the stack machine core.
// Request and response words carry the fixed-width fields of the block.
`default_nettype none
interface smc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] address;
  logic [31:0] write_data;
  logic [31:0] read_value;
  modport source (output valid, command, address, write_data, read_value,
                  input ready);
  modport sink (input valid, command, address, write_data, read_value,
                output ready);
endinterface

interface smc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [31:0] out_value;
  logic [1:0]  status;
  logic        used_input;
  logic [11:0] program_counter;
  modport source (output valid, out_kind, out_value, status, used_input,
                  program_counter, input ready);
  modport sink (input valid, out_kind, out_value, status, used_input,
                program_counter, output ready);
endinterface
`default_nettype wire

[hw/rtl/stack_machine_core.sv]
// Stack machine core: one request word either writes a memory word or
// executes one instruction, and each request gives one response word. MUL,
// DIV and MOD use a bit-serial multiply/divide unit, and a taken jump or
// call scans the program quarter for its LABEL word. All steps share the
// single memory port. Memory is not cleared after reset; MEM_WORDS must be
// a power of two.
// Depends on smc_pkg, smc_if, smc_ram, smc_datapath and smc_ctrl.
`default_nettype none
module stack_machine_core import smc_pkg::*; #(
  parameter int MEM_WORDS = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  smc_in_if.sink   req,
  smc_out_if.source rsp
);
  smc_cmd_t  cmd;
  smc_stat_t st;

  smc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .st(st), .cmd(cmd)
  );

  smc_datapath #(.MEM_WORDS(MEM_WORDS), .WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .in_command(req.command), .in_address(req.address),
    .in_write_data(req.write_data), .in_read_value(req.read_value),
    .out_kind(rsp.out_kind), .out_value(rsp.out_value), .status(rsp.status),
    .used_input(rsp.used_input), .program_counter(rsp.program_counter)
  );
endmodule
`default_nettype wire

[hw/rtl/smc_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module smc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write, or read into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

[hw/rtl/smc_datapath.sv]
// Datapath of the stack machine core: memory, pointers, ALU, shift-add
// multiplier and restoring divider. Depends on smc_pkg and smc_ram.
`default_nettype none
module smc_datapath import smc_pkg::*; #(
  parameter int MEM_WORDS = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  smc_cmd_t    cmd,
  output smc_stat_t   st,
  input  logic        in_command,
  input  logic [11:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_read_value,
  output logic [1:0]  out_kind,
  output logic [31:0] out_value,
  output logic [1:0]  status,
  output logic        used_input,
  output logic [11:0] program_counter
);
  localparam int AW = $clog2(MEM_WORDS);
  localparam int PW = AW - 2;
  localparam int W = WORD_BITS;
  localparam int CW = $clog2(WORD_BITS + 1);
  localparam logic [AW-1:0] DS_BASE = AW'(MEM_WORDS / 4);
  localparam logic [AW-1:0] CS_BASE = AW'((MEM_WORDS / 8) * 3);
  localparam logic [AW-1:0] VS_BASE = AW'(MEM_WORDS / 2);

  logic [AW-1:0] ip, dsp, csp, vsp;
  logic [1:0]    halted;
  logic          in_write;
  logic [AW-1:0] in_addr;
  logic [W-1:0]  in_wdata, rv;
  logic [W-1:0]  opw, a, b, res;
  logic [W-1:0]  md_acc, md_x, md_y;
  logic [CW-1:0] md_cnt;
  logic [PW-1:0] p;
  logic [AW-1:0] p_ext;
  logic [1:0]    kind;
  logic [31:0]   oval;
  logic          used;

  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [W-1:0]  mem_wd, rdata;
  logic [5:0]    op;
  logic [W-1:0]  alu_res, md_res, rem_sh;
  logic          is_mul;

  smc_ram #(.WIDTH(W), .DEPTH(MEM_WORDS)) u_ram (
    .clk(clk), .addr(mem_addr), .we(mem_we), .wdata(mem_wd), .rdata(rdata)
  );

  assign op     = opw[5:0];
  assign p_ext  = {2'b00, p};
  assign is_mul = (op == OP_MUL);
  assign rem_sh = {md_acc[W-2:0], md_x[W-1]};

  // Status toward the controller.
  always_comb begin
    st.op       = op;
    st.op_big   = |opw[W-1:6];
    st.in_write = in_write;
    st.halted   = (halted != HALT_RUN);
    st.lab_hit  = (rdata == W'(OP_LABEL));
    st.lbl_hit  = (rdata == b);
    st.p_last   = (p == {PW{1'b1}});
    st.a_zero   = (a == '0);
    st.md_done  = (md_cnt == CW'(1));
  end

  // Combinational ALU; unary operations work on b.
  always_comb begin
    case (op)
      OP_ADD:  alu_res = a + b;
      OP_SUB:  alu_res = a - b;
      OP_EQ:   alu_res = W'(a == b);
      OP_NE:   alu_res = W'(a != b);
      OP_GT:   alu_res = W'($signed(a) > $signed(b));
      OP_LT:   alu_res = W'($signed(a) < $signed(b));
      OP_GE:   alu_res = W'($signed(a) >= $signed(b));
      OP_LE:   alu_res = W'($signed(a) <= $signed(b));
      OP_SHL:  alu_res = a << b[4:0];
      OP_SHR:  alu_res = $signed(a) >>> b[4:0];
      OP_LAND: alu_res = W'((a != '0) && (b != '0));
      OP_LOR:  alu_res = W'((a != '0) || (b != '0));
      OP_BAND: alu_res = a & b;
      OP_BOR:  alu_res = a | b;
      OP_POS:  alu_res = b;
      OP_NEG:  alu_res = '0 - b;
      OP_NOT:  alu_res = W'(b == '0);
      OP_INV:  alu_res = ~b;
      default: alu_res = a ^ b;
    endcase
  end

  // Sign correction of the multiply/divide unit's raw result.
  always_comb begin
    case (op)
      OP_MUL:  md_res = md_acc;
      OP_DIV:  md_res = (b == '0) ? '0 : ((a[W-1] ^ b[W-1]) ? '0 - md_x : md_x);
      default: md_res = (b == '0) ? '0 : (a[W-1] ? '0 - md_acc : md_acc);
    endcase
  end

  // Memory port selection.
  always_comb begin
    mem_addr = '0;
    mem_we   = 1'b0;
    mem_wd   = '0;
    case (cmd.uop)
      U_MEMWR: begin
        mem_addr = in_addr;
        mem_we   = 1'b1;
        mem_wd   = in_wdata;
      end
      U_FETCH:                 mem_addr = ip;
      U_RDARG:                 mem_addr = ip + AW'(1);
      U_POP, U_PEEK, U_POPB:   mem_addr = dsp - AW'(1);
      U_PUSH_B, U_PUSH_RES, U_PUSH_RV: begin
        mem_addr = dsp;
        mem_we   = 1'b1;
        mem_wd   = (cmd.uop == U_PUSH_B) ? b : ((cmd.uop == U_PUSH_RES) ? res : rv);
      end
      U_DEF: begin
        mem_addr = vsp;
        mem_we   = 1'b1;
      end
      U_ASSIGN: begin
        mem_addr = b[AW-1:0];
        mem_we   = 1'b1;
        mem_wd   = a;
      end
      U_LOADRD:                mem_addr = b[AW-1:0];
      U_CALLPUSH: begin
        mem_addr = csp;
        mem_we   = 1'b1;
        mem_wd   = W'(ip + AW'(1));
      end
      U_RET:                   mem_addr = csp - AW'(1);
      U_SRCH_INIT:             mem_addr = '0;
      U_SRCH_B:                mem_addr = p_ext + AW'(1);
      default:                 mem_addr = '0;
    endcase
    if (cmd.srch_c) begin
      mem_addr = p_ext + AW'(1);
    end
  end

  // Architectural pointers and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      ip     <= '0;
      dsp    <= DS_BASE;
      csp    <= CS_BASE;
      vsp    <= VS_BASE;
      halted <= HALT_RUN;
    end else begin
      case (cmd.uop)
        U_EXIT:                          halted <= HALT_EXIT;
        U_ERR:                           halted <= HALT_ERR;
        U_POP, U_POPB, U_DROP:           dsp <= dsp - AW'(1);
        U_PUSH_B, U_PUSH_RES, U_PUSH_RV: dsp <= dsp + AW'(1);
        U_IP1:                           ip <= ip + AW'(1);
        U_IP2:                           ip <= ip + AW'(2);
        U_DEF:                           vsp <= vsp + AW'(1);
        U_DEL:                           vsp <= vsp - AW'(1);
        U_CALLPUSH:                      csp <= csp + AW'(1);
        U_RET:                           csp <= csp - AW'(1);
        U_RETLD:                         ip <= rdata[AW-1:0] + AW'(1);
        default: ;
      endcase
      if (cmd.srch_c && st.lbl_hit) begin
        ip <= p_ext + AW'(2);
      end
    end
  end

  // Operand, unit and result registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_write <= ~in_command;
      in_addr  <= {{AW{1'b0}}, in_address}[AW-1:0];
      in_wdata <= {{W{in_write_data[31]}}, in_write_data}[W-1:0];
      rv       <= {{W{in_read_value[31]}}, in_read_value}[W-1:0];
      kind     <= KIND_NONE;
      oval     <= '0;
      used     <= 1'b0;
    end
    case (cmd.uop)
      U_DECODE:        opw <= rdata;
      U_LDB, U_POPB:   b <= rdata;
      U_LDA:           a <= rdata;
      U_PUSH_RV:       used <= 1'b1;
      U_ALU:           res <= alu_res;
      U_MD_FIN:        res <= md_res;
      U_WOUT: begin
        oval <= {32'd0, b}[31:0];
        kind <= (op == OP_WI) ? KIND_INT : KIND_CHAR;
      end
      U_MD_START: begin
        md_cnt <= CW'(W);
        md_acc <= '0;
        md_x   <= (is_mul || !a[W-1]) ? a : '0 - a;
        md_y   <= (is_mul || !b[W-1]) ? b : '0 - b;
      end
      U_MD_STEP: begin
        md_cnt <= md_cnt - CW'(1);
        if (is_mul) begin
          md_acc <= md_acc + (md_y[0] ? md_x : '0);
          md_x   <= md_x << 1;
          md_y   <= md_y >> 1;
        end else if (rem_sh >= md_y) begin
          md_acc <= rem_sh - md_y;
          md_x   <= {md_x[W-2:0], 1'b1};
        end else begin
          md_acc <= rem_sh;
          md_x   <= {md_x[W-2:0], 1'b0};
        end
      end
      U_SRCH_INIT:     p <= '0;
      U_SRCH_B: begin
        if (!st.lab_hit && !st.p_last) begin
          p <= p + PW'(1);
        end
      end
      default: ;
    endcase
    if (cmd.srch_c && !st.lbl_hit && !st.p_last) begin
      p <= p + PW'(1);
    end
  end

  assign out_kind        = kind;
  assign out_value       = oval;
  assign status          = halted;
  assign used_input      = used;
  assign program_counter = {12'd0, ip}[11:0];
endmodule
`default_nettype wire

[hw/rtl/smc_ctrl.sv]
// Controller state machine of the stack machine core: sequences the
// datapath micro-operations of each word. Depends on smc_pkg.
`default_nettype none
module smc_ctrl import smc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  input  smc_stat_t st,
  output smc_cmd_t  cmd
);
  state_t state, state_next;
  logic   binop, unop;

  always_comb begin
    binop = (st.op >= OP_ADD && st.op <= OP_BXOR);
    unop  = (st.op >= OP_POS && st.op <= OP_INV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (req_valid) state_next = S_START;
      S_START: begin
        if (st.in_write)    state_next = S_WRITE;
        else if (st.halted) state_next = S_DONE;
        else                state_next = S_FETCH;
      end
      S_WRITE:    state_next = S_DONE;
      S_FETCH:    state_next = S_DECODE;
      S_DECODE:   state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (st.op_big) begin
          state_next = S_ERR;
        end else if (binop || unop) begin
          state_next = S_POP;
        end else begin
          case (st.op)
            OP_EXIT:                          state_next = S_EXIT;
            OP_PUSH, OP_JMP, OP_JZ, OP_JNZ,
            OP_CALL:                          state_next = S_RDARG;
            OP_POP:                           state_next = S_DROP;
            OP_COPY:                          state_next = S_PEEK;
            OP_WI, OP_WC, OP_ASSIGN, OP_LOAD: state_next = S_POP;
            OP_LABEL:                         state_next = S_IP2;
            OP_RET:                           state_next = S_RET;
            OP_RI, OP_RC:                     state_next = S_PUSHRV;
            OP_DEFINE:                        state_next = S_DEF;
            OP_DELETE:                        state_next = S_DEL;
            default:                          state_next = S_ERR;
          endcase
        end
      end
      S_EXIT, S_ERR: state_next = S_DONE;
      S_RDARG: begin
        if (st.op == OP_JZ || st.op == OP_JNZ) state_next = S_POPB;
        else                                   state_next = S_LDB;
      end
      S_POP: begin
        if (binop || st.op == OP_ASSIGN) state_next = S_POPB;
        else                             state_next = S_LDB;
      end
      S_POPB:     state_next = S_LDA;
      S_LDA: begin
        if (st.op == OP_MUL || st.op == OP_DIV || st.op == OP_MOD) begin
          state_next = S_MDSTART;
        end else if (st.op == OP_ASSIGN) begin
          state_next = S_ASSIGN;
        end else if (st.op == OP_JZ || st.op == OP_JNZ) begin
          state_next = S_JDEC;
        end else begin
          state_next = S_ALU;
        end
      end
      S_LDB: begin
        if (unop)                                  state_next = S_ALU;
        else if (st.op == OP_JMP)                  state_next = S_SRCHINIT;
        else if (st.op == OP_CALL)                 state_next = S_CALLPUSH;
        else if (st.op == OP_WI || st.op == OP_WC) state_next = S_WOUT;
        else if (st.op == OP_LOAD)                 state_next = S_LOADRD;
        else                                       state_next = S_PUSHB;
      end
      S_PEEK:     state_next = S_LDB;
      S_LOADRD:   state_next = S_LDB2;
      S_LDB2:     state_next = S_PUSHB;
      S_PUSHB:    state_next = (st.op == OP_PUSH) ? S_IP2 : S_IP1;
      S_ALU:      state_next = S_PUSHRES;
      S_MDSTART:  state_next = S_MDSTEP;
      S_MDSTEP:   if (st.md_done) state_next = S_MDFIN;
      S_MDFIN:    state_next = S_PUSHRES;
      S_PUSHRES, S_PUSHRV, S_DROP, S_WOUT, S_DEF, S_DEL,
      S_ASSIGN:   state_next = S_IP1;
      S_IP1, S_IP2: state_next = S_DONE;
      S_CALLPUSH: state_next = S_SRCHINIT;
      S_RET:      state_next = S_RETLD;
      S_RETLD:    state_next = S_DONE;
      S_JDEC: begin
        if ((st.op == OP_JZ) == st.a_zero) state_next = S_SRCHINIT;
        else                               state_next = S_IP2;
      end
      S_SRCHINIT: state_next = S_SRCHB;
      S_SRCHB: begin
        if (st.lab_hit)     state_next = S_SRCHC;
        else if (st.p_last) state_next = S_ERR;
      end
      S_SRCHC: begin
        if (st.lbl_hit)     state_next = S_DONE;
        else if (st.p_last) state_next = S_ERR;
        else                state_next = S_SRCHB;
      end
      S_DONE:     if (rsp_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd.take   = (state == S_IDLE) && req_valid;
    cmd.srch_c = (state == S_SRCHC);
    req_ready  = (state == S_IDLE);
    rsp_valid  = (state == S_DONE);
    case (state)
      S_WRITE:    cmd.uop = U_MEMWR;
      S_FETCH:    cmd.uop = U_FETCH;
      S_DECODE:   cmd.uop = U_DECODE;
      S_EXIT:     cmd.uop = U_EXIT;
      S_ERR:      cmd.uop = U_ERR;
      S_RDARG:    cmd.uop = U_RDARG;
      S_LDB, S_LDB2: cmd.uop = U_LDB;
      S_LDA:      cmd.uop = U_LDA;
      S_POP:      cmd.uop = U_POP;
      S_POPB:     cmd.uop = U_POPB;
      S_PEEK:     cmd.uop = U_PEEK;
      S_PUSHB:    cmd.uop = U_PUSH_B;
      S_PUSHRES:  cmd.uop = U_PUSH_RES;
      S_PUSHRV:   cmd.uop = U_PUSH_RV;
      S_DROP:     cmd.uop = U_DROP;
      S_IP1:      cmd.uop = U_IP1;
      S_IP2:      cmd.uop = U_IP2;
      S_ALU:      cmd.uop = U_ALU;
      S_MDSTART:  cmd.uop = U_MD_START;
      S_MDSTEP:   cmd.uop = U_MD_STEP;
      S_MDFIN:    cmd.uop = U_MD_FIN;
      S_WOUT:     cmd.uop = U_WOUT;
      S_DEF:      cmd.uop = U_DEF;
      S_DEL:      cmd.uop = U_DEL;
      S_ASSIGN:   cmd.uop = U_ASSIGN;
      S_LOADRD:   cmd.uop = U_LOADRD;
      S_CALLPUSH: cmd.uop = U_CALLPUSH;
      S_RET:      cmd.uop = U_RET;
      S_RETLD:    cmd.uop = U_RETLD;
      S_SRCHINIT: cmd.uop = U_SRCH_INIT;
      S_SRCHB:    cmd.uop = U_SRCH_B;
      default:    cmd.uop = U_NOP;
    endcase
  end
endmodule
`default_nettype wire

[tb/sv/smc_checker.sv]
// Response checker for the stack machine core: mirrors memory, stack pointers and status.
// It predicts one response word per accepted request word and compares them in order.
// Depends on smc_pkg and the smc_in_if / smc_out_if interfaces.
`timescale 1ns / 100ps
module smc_checker import smc_pkg::*; (
  input  logic clk,
  input  logic rst,
  smc_in_if    req,
  smc_out_if   rsp,
  output int   errors,
  output int   pending
);

  typedef struct {
    kind_t       kind;
    logic [31:0] value;
    halt_t       status;
    logic        used;
    logic [11:0] pc;
  } rsp_word_t;

  logic [31:0] mem [4096];
  logic [11:0] ip, dsp, csp, vsp;
  halt_t       run_state;
  rsp_word_t   awaited [$];

  assign pending = awaited.size();

  function automatic void push_word(ref logic [11:0] top, input logic [31:0] v);
    mem[top] = v;
    top = top + 12'd1;
  endfunction

  function automatic logic [31:0] pop_word(ref logic [11:0] top);
    top = top - 12'd1;
    return mem[top];
  endfunction

  function automatic logic [31:0] magnitude(input logic [31:0] x);
    return x[31] ? -x : x;
  endfunction

  // Arithmetic, compare, shift and logic operations on two words.
  function automatic logic [31:0] alu_result(input op_t op, input logic [31:0] l,
                                             input logic [31:0] r);
    logic [31:0] q;
    case (op)
      OP_ADD:  return l + r;
      OP_SUB:  return l - r;
      OP_MUL:  return l * r;
      OP_DIV: begin
        if (r == 0) return 32'd0;
        q = magnitude(l) / magnitude(r);
        return (l[31] != r[31]) ? -q : q;
      end
      OP_MOD: begin
        if (r == 0) return 32'd0;
        q = magnitude(l) % magnitude(r);
        return l[31] ? -q : q;
      end
      OP_EQ:   return {31'd0, l == r};
      OP_NE:   return {31'd0, l != r};
      OP_GT:   return {31'd0, $signed(l) > $signed(r)};
      OP_LT:   return {31'd0, $signed(l) < $signed(r)};
      OP_GE:   return {31'd0, $signed(l) >= $signed(r)};
      OP_LE:   return {31'd0, $signed(l) <= $signed(r)};
      OP_SHL:  return l << r[4:0];
      OP_SHR:  return $unsigned($signed(l) >>> r[4:0]);
      OP_LAND: return {31'd0, (l != 0) && (r != 0)};
      OP_LOR:  return {31'd0, (l != 0) || (r != 0)};
      OP_BAND: return l & r;
      OP_BOR:  return l | r;
      default: return l ^ r;
    endcase
  endfunction

  // Scan the program quarter for the first label word carrying this label.
  function automatic void jump_to(input logic [31:0] lbl);
    for (int p = 0; p < 1024; p++) begin
      if (mem[p] == 32'(OP_LABEL) && mem[12'(p + 1)] == lbl) begin
        ip = 12'(p + 2);
        return;
      end
    end
    run_state = HALT_ERR;
  endfunction

  // Execute the instruction at the program counter.
  function automatic void run_instr(input logic [31:0] rv, inout rsp_word_t e);
    logic [31:0] w, l, r;
    op_t         op;
    w = mem[ip];
    op = op_t'(w[5:0]);
    if (w[31:6] != 0) begin
      run_state = HALT_ERR;
      return;
    end
    case (op)
      OP_EXIT: begin
        run_state = HALT_EXIT;
        return;
      end
      OP_PUSH: begin
        push_word(dsp, mem[ip + 12'd1]);
        ip = ip + 12'd2;
        return;
      end
      OP_POP: dsp = dsp - 12'd1;
      OP_COPY: push_word(dsp, mem[dsp - 12'd1]);
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE,
      OP_LE, OP_SHL, OP_SHR, OP_LAND, OP_LOR, OP_BAND, OP_BOR, OP_BXOR: begin
        r = pop_word(dsp);
        l = pop_word(dsp);
        push_word(dsp, alu_result(op, l, r));
      end
      OP_POS, OP_NEG, OP_NOT, OP_INV: begin
        l = pop_word(dsp);
        if (op == OP_NEG) l = -l;
        else if (op == OP_NOT) l = {31'd0, l == 0};
        else if (op == OP_INV) l = ~l;
        push_word(dsp, l);
      end
      OP_LABEL: begin
        ip = ip + 12'd2;
        return;
      end
      OP_JMP: begin
        jump_to(mem[ip + 12'd1]);
        return;
      end
      OP_JZ, OP_JNZ: begin
        l = pop_word(dsp);
        if ((op == OP_JZ) == (l == 0)) jump_to(mem[ip + 12'd1]);
        else ip = ip + 12'd2;
        return;
      end
      OP_CALL: begin
        l = mem[ip + 12'd1];
        push_word(csp, {20'd0, ip + 12'd1});
        jump_to(l);
        return;
      end
      OP_RET: begin
        l = pop_word(csp);
        ip = l[11:0] + 12'd1;
        return;
      end
      OP_WI, OP_WC: begin
        e.value = pop_word(dsp);
        e.kind = (op == OP_WI) ? KIND_INT : KIND_CHAR;
      end
      OP_RI, OP_RC: begin
        push_word(dsp, rv);
        e.used = 1'b1;
      end
      OP_DEFINE: push_word(vsp, 32'd0);
      OP_DELETE: vsp = vsp - 12'd1;
      OP_ASSIGN: begin
        r = pop_word(dsp);
        l = pop_word(dsp);
        mem[r[11:0]] = l;
      end
      OP_LOAD: begin
        l = pop_word(dsp);
        push_word(dsp, mem[l[11:0]]);
      end
      default: begin
        run_state = HALT_ERR;
        return;
      end
    endcase
    ip = ip + 12'd1;
  endfunction

  // Predict on every accepted request word, check every accepted response word.
  always @(posedge clk) begin
    rsp_word_t e, got;
    if (rst) begin
      ip <= 12'd0;
      dsp <= 12'd1024;
      csp <= 12'd1536;
      vsp <= 12'd2048;
      run_state <= HALT_RUN;
      errors <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.kind = kind_t'(rsp.out_kind);
        got.value = rsp.out_value;
        got.status = halt_t'(rsp.status);
        got.used = rsp.used_input;
        got.pc = rsp.program_counter;
        if (awaited.size() == 0) begin
          $error("response word with no request outstanding");
          errors <= errors + 1;
        end else begin
          e = awaited.pop_front();
          if (got.kind !== e.kind || got.value !== e.value || got.status !== e.status ||
              got.used !== e.used || got.pc !== e.pc)
            errors <= errors + 1;
          if (got.kind !== e.kind)
            $error("out_kind: expected %0d, got %0d", e.kind, got.kind);
          if (got.value !== e.value)
            $error("out_value: expected %h, got %h", e.value, got.value);
          if (got.status !== e.status)
            $error("status: expected %0d, got %0d", e.status, got.status);
          if (got.used !== e.used)
            $error("used_input: expected %b, got %b", e.used, got.used);
          if (got.pc !== e.pc)
            $error("program_counter: expected %h, got %h", e.pc, got.pc);
        end
      end
      if (req.valid && req.ready) begin
        e.kind = KIND_NONE;
        e.value = 32'd0;
        e.used = 1'b0;
        if (!req.command) mem[req.address] = req.write_data;
        else if (run_state == HALT_RUN) run_instr(req.read_value, e);
        e.status = run_state;
        e.pc = ip;
        awaited.push_back(e);
      end
    end
  end

endmodule

[tb/sv/stack_machine_core_tb.sv]
// Top of the stack machine core testbench: clock, reset, request and response traffic.
// Fills memory, runs directed and random programs, ends with a halt; smc_checker judges.
// Depends on smc_pkg, smc_if, stack_machine_core and smc_checker.
`timescale 1ns / 100ps
module stack_machine_core_tb import smc_pkg::*;;

  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_STEPS = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic idle_on = 1'b1;
  logic [11:0] pc = 12'd0;
  int   errors, pending, stall_left, quiet_cycles;

  smc_in_if  req ();
  smc_out_if rsp ();

  stack_machine_core dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  smc_checker watch (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .errors(errors),
                     .pending(pending));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls come in bursts.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one request word and wait for its response; the next pc comes back with it.
  task automatic transfer(input logic cmd, input logic [11:0] addr,
                          input logic [31:0] wdata, input logic [31:0] rval);
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 9)) @(posedge clk);
    req.valid <= 1'b1;
    req.command <= cmd;
    req.address <= addr;
    req.write_data <= wdata;
    req.read_value <= rval;
    do @(posedge clk); while (!req.ready);
    req.valid <= 1'b0;
    do @(posedge clk); while (!(rsp.valid && rsp.ready));
    pc = rsp.program_counter;
  endtask

  task automatic mem_write(input logic [11:0] addr, input logic [31:0] w);
    transfer(1'b0, addr, w, $urandom);
  endtask

  // Place an instruction at the program counter, then execute it.
  task automatic exec_op(input logic [31:0] op_word, input logic [31:0] arg);
    logic [11:0] at;
    at = pc;
    mem_write(at, op_word);
    mem_write(at + 12'd1, arg);
    transfer(1'b1, 12'($urandom), $urandom, $urandom);
  endtask

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5, 6: return 32'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  // A jump target: write a label pair clear of the jump instruction itself.
  task automatic place_label(input logic [31:0] lbl);
    logic [11:0] la;
    do la = 12'($urandom_range(0, 1021)); while (12'(la - pc + 12'd2) < 12'd4);
    mem_write(la, 32'(OP_LABEL));
    mem_write(la + 12'd1, lbl);
  endtask

  task automatic branch_op(input op_t op);
    logic [31:0] lbl;
    lbl = $urandom;
    place_label(lbl);
    exec_op(32'(op), lbl);
  endtask

  task automatic push_val(input logic [31:0] v);
    exec_op(32'(OP_PUSH), v);
  endtask

  task automatic binary(input logic [31:0] l, input logic [31:0] r, input op_t op);
    push_val(l);
    push_val(r);
    exec_op(32'(op), $urandom);
  endtask

  initial begin
    op_t ops [] = '{OP_POP, OP_COPY, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ,
                    OP_NE, OP_GT, OP_LT, OP_GE, OP_LE, OP_SHL, OP_SHR, OP_LAND,
                    OP_LOR, OP_BAND, OP_BOR, OP_BXOR, OP_POS, OP_NEG, OP_NOT,
                    OP_INV, OP_LABEL, OP_JMP, OP_JZ, OP_JNZ, OP_CALL, OP_RET,
                    OP_WI, OP_WC, OP_RI, OP_RC, OP_DEFINE, OP_DELETE, OP_ASSIGN,
                    OP_LOAD};
    logic [31:0] bad_codes [] = '{32'd3, 32'd35, 32'd38, 32'd39, 32'd44, 32'd63,
                                  32'h8000_0001};
    op_t op;
    req.valid <= 1'b0;
    req.command <= 1'b0;
    req.address <= 12'd0;
    req.write_data <= 32'd0;
    req.read_value <= 32'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every memory word gets a value first, so no read ever sees an unwritten word.
    for (int a = 0; a < 4096; a++) mem_write(12'(a), edge_value());

    // Directed: overflow, division corners, shifts, unary, I/O, variables, branches.
    binary(32'h7FFF_FFFF, 32'd1, OP_ADD);
    binary(32'h8000_0000, 32'hFFFF_FFFF, OP_DIV);
    binary(32'h8000_0000, 32'hFFFF_FFFF, OP_MOD);
    binary(32'd5, 32'd0, OP_DIV);
    binary(32'hFFFF_FFF9, 32'd0, OP_MOD);
    binary(32'hFFFF_FFF9, 32'd2, OP_MOD);
    binary(32'hFFFF_FFF8, 32'd33, OP_SHR);
    binary(32'd1, 32'hFFFF_FFFF, OP_SHL);
    exec_op(32'(OP_NEG), 0);
    exec_op(32'(OP_WI), 0);
    push_val(32'h1234_5641);
    exec_op(32'(OP_WC), 0);
    exec_op(32'(OP_RI), 0);
    exec_op(32'(OP_RC), 0);
    exec_op(32'(OP_NOT), 0);
    exec_op(32'(OP_INV), 0);
    exec_op(32'(OP_DEFINE), 0);
    exec_op(32'(OP_DELETE), 0);
    binary(32'hCAFE_0001, 32'h0000_F123, OP_ASSIGN);
    push_val(32'h0000_F123);
    exec_op(32'(OP_LOAD), 0);
    exec_op(32'(OP_LABEL), $urandom);
    push_val(32'd1);
    branch_op(OP_JZ);
    push_val(32'd0);
    branch_op(OP_JNZ);
    branch_op(OP_CALL);
    exec_op(32'(OP_RET), 0);

    // Random programs, mostly with defined jump targets; no idling near the end.
    for (int i = 0; i < RANDOM_STEPS; i++) begin
      if (i == RANDOM_STEPS - 150) idle_on = 1'b0;
      if ($urandom_range(0, 9) < 3) begin
        push_val(edge_value());
      end else begin
        op = ops[$urandom_range(0, ops.size() - 1)];
        if (op inside {OP_JMP, OP_JZ, OP_JNZ, OP_CALL}) branch_op(op);
        else exec_op(32'(op), edge_value());
      end
    end

    // One way to halt, then steps and a write while halted.
    case ($urandom_range(0, 2))
      0: exec_op(32'(OP_EXIT), 0);
      1: exec_op(bad_codes[$urandom_range(0, bad_codes.size() - 1)], 0);
      default: exec_op(32'(OP_JMP), $urandom);
    endcase
    transfer(1'b1, 12'd0, 32'd0, $urandom);
    mem_write(12'($urandom), $urandom);
    transfer(1'b1, 12'd0, 32'd0, $urandom);

    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
